// File: hdl/launch_sequencer_defines.svh
// Assertion macros shared by the launch sequencer RTL.
`ifndef LAUNCH_SEQUENCER_DEFINES_SVH
`define LAUNCH_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS

// Checked at every rising edge while reset is released.
`define LS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define LS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define LS_ASSERT(lbl, clk, rst_n, prop, msg)
`define LS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: hdl/ls_pkg.sv
// Types and constants of the launch sequencer.
package ls_pkg;

  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WHEELED         = 3'd0,
    CFG_THROTTLE_MIN    = 3'd1,
    CFG_THROTTLE_MAX    = 3'd2,
    CFG_RAMP_STEP       = 3'd3,
    CFG_RAMP_PERIOD_MS  = 3'd4,
    CFG_IDLE_SPINUP_MS  = 3'd5,
    CFG_EXIT_TIMEOUT_MS = 3'd6,
    CFG_DETECT_MS       = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BEEP_NONE     = 2'd0,
    BEEP_WAITING  = 2'd1,
    BEEP_LAUNCHED = 2'd2
  } beep_e;

  // Register reset values
  localparam logic        RstWheeled      = 1'b0;
  localparam logic [10:0] RstThrottleMin  = 11'd1100;
  localparam logic [10:0] RstThrottleMax  = 11'd1700;
  localparam logic [8:0]  RstRampStep     = 9'd100;
  localparam logic [15:0] RstRampPeriod   = 16'd300;
  localparam logic [15:0] RstIdleSpinup   = 16'd1500;
  localparam logic [15:0] RstExitTimeout  = 16'd5000;
  localparam logic [15:0] RstDetect       = 16'd40;

  localparam logic [10:0]        RampReset     = 11'd1000;
  localparam logic [11:0]        PitchHoldRx   = 12'd1400;
  localparam logic signed [15:0] BankPitchLim  = -16'sd450;
  localparam logic [16:0]        SwingRateMin  = 17'd1746;
  localparam logic [15:0]        FwdSpeedMin   = 16'd300;

  typedef struct packed {
    logic        wheeled;
    logic [10:0] throttle_min;
    logic [10:0] throttle_max;
    logic [8:0]  ramp_step;
    logic [15:0] ramp_period_ms;
    logic [15:0] idle_spinup_ms;
    logic [15:0] exit_timeout_ms;
    logic [15:0] detect_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic               plane_enabled;
    logic               launch_mode_on;
    logic               throttle_mid;
    logic               armed;
    logic signed [15:0] pitch_accel;
    logic signed [15:0] roll_accel;
    logic signed [15:0] yaw_rate_mrad;
    logic               tilt_ok;
    logic [15:0]        ground_speed;
    logic [11:0]        rx_throttle;
    logic               sticks_moved;
  } item_t;

  typedef struct packed {
    logic        throttle_write;
    logic [10:0] throttle_cmd;
    logic        attitude_write;
    logic        arm_request;
    logic [1:0]  beep;
    logic        beep_silence;
    logic        launch_done;
  } res_t;

endpackage

// File: hdl/ls_cfg.sv
// Configuration register file of the launch sequencer.
module ls_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ls_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [ls_pkg::CfgDataW-1:0]   cfg_data_i,
  output ls_pkg::cfg_t                  cfg_o
);

  ls_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (ls_pkg::cfg_idx_e'(cfg_idx_i))
        ls_pkg::CFG_WHEELED:         cfg_d.wheeled         = cfg_data_i[0];
        ls_pkg::CFG_THROTTLE_MIN:    cfg_d.throttle_min    = cfg_data_i[10:0];
        ls_pkg::CFG_THROTTLE_MAX:    cfg_d.throttle_max    = cfg_data_i[10:0];
        ls_pkg::CFG_RAMP_STEP:       cfg_d.ramp_step       = cfg_data_i[8:0];
        ls_pkg::CFG_RAMP_PERIOD_MS:  cfg_d.ramp_period_ms  = cfg_data_i;
        ls_pkg::CFG_IDLE_SPINUP_MS:  cfg_d.idle_spinup_ms  = cfg_data_i;
        ls_pkg::CFG_EXIT_TIMEOUT_MS: cfg_d.exit_timeout_ms = cfg_data_i;
        ls_pkg::CFG_DETECT_MS:       cfg_d.detect_ms       = cfg_data_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wheeled         <= ls_pkg::RstWheeled;
      cfg_q.throttle_min    <= ls_pkg::RstThrottleMin;
      cfg_q.throttle_max    <= ls_pkg::RstThrottleMax;
      cfg_q.ramp_step       <= ls_pkg::RstRampStep;
      cfg_q.ramp_period_ms  <= ls_pkg::RstRampPeriod;
      cfg_q.idle_spinup_ms  <= ls_pkg::RstIdleSpinup;
      cfg_q.exit_timeout_ms <= ls_pkg::RstExitTimeout;
      cfg_q.detect_ms       <= ls_pkg::RstDetect;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/ls_cue.sv
// Throw cue detector: banked pitch-down, swing, or forward GPS motion.
module ls_cue (
  input  ls_pkg::item_t item_i,
  output logic          cue_o
);

  logic signed [15:0] pitch, roll, yaw;
  logic signed [16:0] yaw_ext, yaw_abs;
  logic signed [20:0] roll10, yaw3;
  logic               pitch_pos, roll_pos, yaw_pos;
  logic               banked, swing, fwd;

  assign pitch = $signed(item_i.pitch_accel);
  assign roll  = $signed(item_i.roll_accel);
  assign yaw   = $signed(item_i.yaw_rate_mrad);

  assign pitch_pos = !pitch[15] && (pitch != 16'sd0);
  assign roll_pos  = !roll[15] && (roll != 16'sd0);
  assign yaw_pos   = !yaw[15] && (yaw != 16'sd0);

  assign yaw_ext = {yaw[15], yaw};
  assign yaw_abs = yaw[15] ? -yaw_ext : yaw_ext;

  // roll*1000/yaw > 300, cross-multiplied with the sign of yaw
  assign roll10 = {{5{roll[15]}}, roll} * 21'sd10;
  assign yaw3   = {{5{yaw[15]}}, yaw} * 21'sd3;

  assign banked = (pitch < ls_pkg::BankPitchLim) && item_i.tilt_ok;
  assign swing  = ($unsigned(yaw_abs) >= ls_pkg::SwingRateMin) && pitch_pos &&
                  (yaw_pos ? (roll10 > yaw3) : (roll10 < yaw3));
  assign fwd    = roll_pos && (item_i.ground_speed > ls_pkg::FwdSpeedMin);

  assign cue_o = banked || swing || fwd;

endmodule

// File: hdl/ls_step.sv
// Launch sequence state and the per-tick step logic.
`include "launch_sequencer_defines.svh"

module ls_step (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  ls_pkg::item_t item_i,
  input  ls_pkg::cfg_t  cfg_i,
  input  logic          cue_i,
  output ls_pkg::res_t  res_o
);

  logic [15:0] detect_sum_q, detect_sum_d;
  logic [31:0] detect_prev_q, detect_prev_d;
  logic        active_q, active_d;
  logic        once_q, once_d;
  logic        finished_q, finished_d;
  logic        peak_q, peak_d;
  logic        tmo_armed_q, tmo_armed_d;
  logic [10:0] ramp_q, ramp_d;
  logic [31:0] ramp_start_q, ramp_start_d;
  logic [31:0] tmo_start_q, tmo_start_d;

  logic [31:0] now;
  logic [31:0] ramp_dt, tmo_dt, det_dt;
  logic [11:0] ramp_sum;
  logic [32:0] det_sum;
  logic [15:0] det_sat;
  logic        wheels, hold_rx, timed_out;
  ls_pkg::res_t res;

  assign now      = item_i.now_ms;
  assign wheels   = cfg_i.wheeled;
  assign hold_rx  = item_i.rx_throttle >= ls_pkg::PitchHoldRx;
  assign ramp_dt  = now - ramp_start_q;
  assign tmo_dt   = now - tmo_start_q;
  assign det_dt   = now - detect_prev_q;
  assign ramp_sum = {1'b0, ramp_q} + {3'b0, cfg_i.ramp_step};
  assign det_sum  = {17'b0, detect_sum_q} + {1'b0, det_dt};
  assign det_sat  = (det_sum[32:16] != 17'd0) ? 16'hFFFF : det_sum[15:0];

  always_comb begin
    detect_sum_d  = detect_sum_q;
    detect_prev_d = detect_prev_q;
    active_d      = active_q;
    once_d        = once_q;
    finished_d    = finished_q;
    peak_d        = peak_q;
    tmo_armed_d   = tmo_armed_q;
    ramp_d        = ramp_q;
    ramp_start_d  = ramp_start_q;
    tmo_start_d   = tmo_start_q;
    timed_out     = 1'b0;
    res           = '0;

    if (item_i.plane_enabled) begin
      if (item_i.launch_mode_on && item_i.throttle_mid && !finished_q) begin
        res.beep = active_q ? ls_pkg::BEEP_LAUNCHED : ls_pkg::BEEP_WAITING;
        if (wheels) begin
          active_d           = 1'b1;
          res.arm_request    = !item_i.armed;
          res.throttle_write = 1'b1;
          res.throttle_cmd   = ramp_q;
          if (ramp_dt >= {16'b0, cfg_i.ramp_period_ms}) begin
            if (peak_q) begin
              if (ramp_q < cfg_i.throttle_max) begin
                ramp_d = ramp_sum[11] ? 11'h7FF : ramp_sum[10:0];
              end else begin
                ramp_d = cfg_i.throttle_max;
              end
            end
            peak_d       = 1'b1;
            ramp_start_d = now;
          end
        end

        if (active_d) begin
          if (!wheels) begin
            // hand launch: idle at minimum, then full throttle after the spinup delay
            if (ramp_dt >= {16'b0, cfg_i.idle_spinup_ms}) begin
              if (peak_q) begin
                res.throttle_write = 1'b1;
                res.throttle_cmd   = cfg_i.throttle_max;
                res.beep_silence   = 1'b1;
              end else begin
                ramp_start_d = now;
              end
              peak_d = 1'b1;
            end else begin
              res.throttle_write = 1'b1;
              res.throttle_cmd   = cfg_i.throttle_min;
            end
          end
          if (!wheels || hold_rx) res.attitude_write = 1'b1;
          if (!item_i.armed) res.arm_request = 1'b1;
          // timeout fires on the second expiry; the first one restarts the window
          if (cfg_i.exit_timeout_ms != 16'd0 && tmo_dt >= {16'b0, cfg_i.exit_timeout_ms}) begin
            if (tmo_armed_q) begin
              timed_out = 1'b1;
            end else begin
              tmo_start_d = now;
              tmo_armed_d = 1'b1;
            end
          end
          if (timed_out || item_i.sticks_moved) begin
            finished_d = 1'b1;
            active_d   = 1'b0;
          end
          once_d = 1'b1;
        end else if (!once_q && !wheels) begin
          detect_prev_d = now;
          if (cue_i) begin
            detect_sum_d = det_sat;
            if (det_sat >= cfg_i.detect_ms) active_d = 1'b1;
          end else begin
            detect_sum_d = 16'd0;
          end
        end

        if (!finished_d && (!wheels || (hold_rx && active_d))) res.attitude_write = 1'b1;
      end

      // disarmed with throttle off center restarts the sequence
      if (!item_i.armed && !item_i.throttle_mid) begin
        once_d       = 1'b0;
        finished_d   = 1'b0;
        peak_d       = 1'b0;
        tmo_armed_d  = 1'b0;
        ramp_d       = ls_pkg::RampReset;
        ramp_start_d = '0;
        tmo_start_d  = '0;
      end
    end

    res.launch_done = finished_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      detect_sum_q  <= '0;
      detect_prev_q <= '0;
      active_q      <= 1'b0;
      once_q        <= 1'b0;
      finished_q    <= 1'b0;
      peak_q        <= 1'b0;
      tmo_armed_q   <= 1'b0;
      ramp_q        <= ls_pkg::RampReset;
      ramp_start_q  <= '0;
      tmo_start_q   <= '0;
    end else if (en_i) begin
      detect_sum_q  <= detect_sum_d;
      detect_prev_q <= detect_prev_d;
      active_q      <= active_d;
      once_q        <= once_d;
      finished_q    <= finished_d;
      peak_q        <= peak_d;
      tmo_armed_q   <= tmo_armed_d;
      ramp_q        <= ramp_d;
      ramp_start_q  <= ramp_start_d;
      tmo_start_q   <= tmo_start_d;
    end
  end

  assign res_o = res;

  `LS_ASSERT(a_fin_not_active, clk_i, rst_ni, finished_q |-> !active_q, "finished while active")
  `LS_ASSERT(a_state_hold, clk_i, rst_ni, !en_i |=> $stable(ramp_q) && $stable(finished_q),
             "state moved without an item")

endmodule

// File: hdl/launch_sequencer.sv
// Top level of the fixed-wing auto-launch sequencer.
//
// One input item is one control tick (time, mode and arm flags, IMU and GPS
// readings); each item yields exactly one result item with the throttle,
// attitude, arm and beeper commands of that tick.
// Both channels use valid/stall: an item moves on a rising edge with valid
// high and stall low. Configuration registers are written through the
// cfg_we_i/cfg_idx_i/cfg_data_i port, one register per edge; the user must
// write them only while idle, which the block does not enforce. An accepted
// item moves on from the input register when the result register is free.
// Throughput: one item per cycle unless the result stalls; the sequence state
// is updated in the same cycle that a tick moves into the result register.
// A stalled result holds; the input register still takes one more item, and
// in_stall_o rises once that register is full behind a stalled result.
// Reset clears both registers' valid flags, returns every configuration
// register to its default and restarts the launch sequence state.
`include "launch_sequencer_defines.svh"

module launch_sequencer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ls_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ls_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [31:0]                 now_ms_i,
  input  logic                        plane_enabled_i,
  input  logic                        launch_mode_on_i,
  input  logic                        throttle_mid_i,
  input  logic                        armed_i,
  input  logic signed [15:0]          pitch_accel_i,
  input  logic signed [15:0]          roll_accel_i,
  input  logic signed [15:0]          yaw_rate_mrad_i,
  input  logic                        tilt_ok_i,
  input  logic [15:0]                 ground_speed_i,
  input  logic [11:0]                 rx_throttle_i,
  input  logic                        sticks_moved_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        throttle_write_o,
  output logic [10:0]                 throttle_cmd_o,
  output logic                        attitude_write_o,
  output logic                        arm_request_o,
  output logic [1:0]                  beep_o,
  output logic                        beep_silence_o,
  output logic                        launch_done_o
);

  ls_pkg::cfg_t  cfg;
  ls_pkg::item_t item_q;
  ls_pkg::res_t  res, res_q;
  logic          in_vld_q, in_vld_d;
  logic          out_vld_q, out_vld_d;
  logic          in_take, out_free, step_fire, cue;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign step_fire  = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  assign in_vld_d  = in_take || (in_vld_q && !step_fire);
  assign out_vld_d = step_fire || (out_vld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.now_ms         <= now_ms_i;
      item_q.plane_enabled  <= plane_enabled_i;
      item_q.launch_mode_on <= launch_mode_on_i;
      item_q.throttle_mid   <= throttle_mid_i;
      item_q.armed          <= armed_i;
      item_q.pitch_accel    <= pitch_accel_i;
      item_q.roll_accel     <= roll_accel_i;
      item_q.yaw_rate_mrad  <= yaw_rate_mrad_i;
      item_q.tilt_ok        <= tilt_ok_i;
      item_q.ground_speed   <= ground_speed_i;
      item_q.rx_throttle    <= rx_throttle_i;
      item_q.sticks_moved   <= sticks_moved_i;
    end
    if (step_fire) begin
      res_q <= res;
    end
  end

  ls_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ls_cue u_cue (
    .item_i (item_q),
    .cue_o  (cue)
  );

  ls_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (step_fire),
    .item_i (item_q),
    .cfg_i  (cfg),
    .cue_i  (cue),
    .res_o  (res)
  );

  assign out_valid_o      = out_vld_q;
  assign throttle_write_o = res_q.throttle_write;
  assign throttle_cmd_o   = res_q.throttle_cmd;
  assign attitude_write_o = res_q.attitude_write;
  assign arm_request_o    = res_q.arm_request;
  assign beep_o           = res_q.beep;
  assign beep_silence_o   = res_q.beep_silence;
  assign launch_done_o    = res_q.launch_done;

  `LS_ASSERT_ALWAYS(a_stall_only_full, clk_i, in_stall_o |-> in_vld_q,
                    "input stalled with an empty input register")
  `LS_ASSERT(a_cmd_zero, clk_i, rst_ni, out_vld_q && !res_q.throttle_write |-> res_q.throttle_cmd == 11'd0,
             "throttle command without a throttle write")
  `LS_ASSERT(a_silence_full, clk_i, rst_ni, out_vld_q && res_q.beep_silence |-> res_q.throttle_write,
             "beeper silenced without launch throttle")

endmodule

// File: test/launch_sequencer_tb.sv
// Self-checking testbench for the launch sequencer: random control ticks, predicted commands.
`timescale 1ns / 1ps

module launch_sequencer_tb;

  localparam int LongHold = 300;

  logic                        clk = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we = 1'b0;
  ls_pkg::cfg_idx_e            cfg_idx = ls_pkg::CFG_WHEELED;
  logic [ls_pkg::CfgDataW-1:0] cfg_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall_o;
  ls_pkg::item_t               drv = '0;
  logic                        out_valid_o;
  logic                        out_stall = 1'b0;
  logic                        throttle_write_o;
  logic [10:0]                 throttle_cmd_o;
  logic                        attitude_write_o;
  logic                        arm_request_o;
  logic [1:0]                  beep_o;
  logic                        beep_silence_o;
  logic                        launch_done_o;

  launch_sequencer u_top (
    .clk_i            (clk),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall_o),
    .now_ms_i         (drv.now_ms),
    .plane_enabled_i  (drv.plane_enabled),
    .launch_mode_on_i (drv.launch_mode_on),
    .throttle_mid_i   (drv.throttle_mid),
    .armed_i          (drv.armed),
    .pitch_accel_i    (drv.pitch_accel),
    .roll_accel_i     (drv.roll_accel),
    .yaw_rate_mrad_i  (drv.yaw_rate_mrad),
    .tilt_ok_i        (drv.tilt_ok),
    .ground_speed_i   (drv.ground_speed),
    .rx_throttle_i    (drv.rx_throttle),
    .sticks_moved_i   (drv.sticks_moved),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall),
    .throttle_write_o (throttle_write_o),
    .throttle_cmd_o   (throttle_cmd_o),
    .attitude_write_o (attitude_write_o),
    .arm_request_o    (arm_request_o),
    .beep_o           (beep_o),
    .beep_silence_o   (beep_silence_o),
    .launch_done_o    (launch_done_o)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the registers and the sequence state
  ls_pkg::cfg_t regs;
  logic [15:0]  cue_ms;
  logic [31:0]  cue_t;
  logic         airborne, launched_before, seq_done, peak_seen, tmo_primed;
  logic [10:0]  ramp_thr;
  logic [31:0]  ramp_t0, tmo_t0;

  ls_pkg::res_t cmds_due[$];
  logic [31:0]  tick_ms = '0;
  bit           no_idle = 1'b0;
  bit           hold_req = 1'b0;
  int           err_count = 0;
  int           ticks_sent = 0;
  int           results_seen = 0;
  int           phases = 0;

  function automatic void restart_sequence();
    launched_before = 1'b0;
    seq_done        = 1'b0;
    peak_seen       = 1'b0;
    tmo_primed      = 1'b0;
    ramp_thr        = ls_pkg::RampReset;
    ramp_t0         = '0;
    tmo_t0          = '0;
  endfunction

  function automatic ls_pkg::res_t launch_cmds_for(input ls_pkg::item_t t);
    ls_pkg::res_t r;
    logic [31:0]  dt;
    logic [11:0]  ramp_sum;
    int           pitch, roll, yaw, ay;
    bit           banked, swing, fwd, tmo;
    r = '0;
    if (t.plane_enabled) begin
      if (t.launch_mode_on && t.throttle_mid && !seq_done) begin
        r.beep = airborne ? ls_pkg::BEEP_LAUNCHED : ls_pkg::BEEP_WAITING;
        if (regs.wheeled) begin
          airborne = 1'b1;
          if (!t.armed) r.arm_request = 1'b1;
          r.throttle_write = 1'b1;
          r.throttle_cmd   = ramp_thr;
          dt = t.now_ms - ramp_t0;
          if (dt >= regs.ramp_period_ms) begin
            // first period only arms the ramp
            if (peak_seen) begin
              if (ramp_thr < regs.throttle_max) begin
                ramp_sum = {1'b0, ramp_thr} + regs.ramp_step;
                ramp_thr = (ramp_sum > 12'd2047) ? 11'h7FF : ramp_sum[10:0];
              end else begin
                ramp_thr = regs.throttle_max;
              end
            end
            peak_seen = 1'b1;
            ramp_t0   = t.now_ms;
          end
        end
        if (airborne) begin
          if (!regs.wheeled) begin
            dt = t.now_ms - ramp_t0;
            if (dt >= regs.idle_spinup_ms) begin
              // a stale start is restarted once before full throttle
              if (peak_seen) begin
                r.throttle_write = 1'b1;
                r.throttle_cmd   = regs.throttle_max;
                r.beep_silence   = 1'b1;
              end else begin
                ramp_t0 = t.now_ms;
              end
              peak_seen = 1'b1;
            end else begin
              r.throttle_write = 1'b1;
              r.throttle_cmd   = regs.throttle_min;
            end
          end
          if (!regs.wheeled || t.rx_throttle >= ls_pkg::PitchHoldRx) r.attitude_write = 1'b1;
          if (!t.armed) r.arm_request = 1'b1;
          tmo = 1'b0;
          if (regs.exit_timeout_ms != 0) begin
            dt = t.now_ms - tmo_t0;
            if (dt >= regs.exit_timeout_ms) begin
              if (tmo_primed) begin
                tmo = 1'b1;
              end else begin
                tmo_t0     = t.now_ms;
                tmo_primed = 1'b1;
              end
            end
          end
          if (tmo || t.sticks_moved) begin
            seq_done = 1'b1;
            airborne = 1'b0;
          end
          launched_before = 1'b1;
        end else if (!launched_before && !regs.wheeled) begin
          pitch  = $signed(t.pitch_accel);
          roll   = $signed(t.roll_accel);
          yaw    = $signed(t.yaw_rate_mrad);
          banked = (pitch < int'(ls_pkg::BankPitchLim)) && t.tilt_ok;
          fwd    = (roll > 0) && (t.ground_speed > ls_pkg::FwdSpeedMin);
          swing  = 1'b0;
          ay     = (yaw < 0) ? -yaw : yaw;
          // roll/yaw > 0.3 without a division
          if (ay >= int'(ls_pkg::SwingRateMin) && pitch > 0)
            swing = (yaw > 0) ? (roll * 10 > yaw * 3) : (roll * 10 < yaw * 3);
          if (banked || swing || fwd) begin
            dt = t.now_ms - cue_t;
            if (dt > 32'hFFFF - {16'h0, cue_ms}) cue_ms = 16'hFFFF;
            else cue_ms = cue_ms + dt[15:0];
            cue_t = t.now_ms;
            if (cue_ms >= regs.detect_ms) airborne = 1'b1;
          end else begin
            cue_t  = t.now_ms;
            cue_ms = '0;
          end
        end
        if (!seq_done) begin
          if (!regs.wheeled || (t.rx_throttle >= ls_pkg::PitchHoldRx && airborne))
            r.attitude_write = 1'b1;
        end
      end
      if (!t.armed && !t.throttle_mid) restart_sequence();
    end
    if (!r.throttle_write) r.throttle_cmd = '0;
    r.launch_done = seq_done;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    err_count++;
    if (err_count <= 40)
      $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Result checker
  always @(posedge clk) begin : check_res
    ls_pkg::res_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      results_seen++;
      if (cmds_due.size() == 0) begin
        report_mismatch("result item with no tick pending", 16'd1, 16'd0);
      end else begin
        want = cmds_due.pop_front();
        if (throttle_write_o !== want.throttle_write)
          report_mismatch("throttle_write", throttle_write_o, want.throttle_write);
        if (throttle_cmd_o !== want.throttle_cmd)
          report_mismatch("throttle_cmd", throttle_cmd_o, want.throttle_cmd);
        if (attitude_write_o !== want.attitude_write)
          report_mismatch("attitude_write", attitude_write_o, want.attitude_write);
        if (arm_request_o !== want.arm_request)
          report_mismatch("arm_request", arm_request_o, want.arm_request);
        if (beep_o !== want.beep)
          report_mismatch("beep", beep_o, want.beep);
        if (beep_silence_o !== want.beep_silence)
          report_mismatch("beep_silence", beep_silence_o, want.beep_silence);
        if (launch_done_o !== want.launch_done)
          report_mismatch("launch_done", launch_done_o, want.launch_done);
      end
    end
  end

  // Output side: random stall per result, one long hold on request
  initial begin : out_side
    int n;
    wait (rst_ni);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 8);
      if (hold_req) begin
        n        = LongHold;
        hold_req = 1'b0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid_o);
    end
  end

  task automatic send_tick(input ls_pkg::item_t t);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    drv      <= t;
    do @(posedge clk); while (in_stall_o);
    cmds_due.push_back(launch_cmds_for(t));
    ticks_sent++;
  endtask

  task automatic drain_ticks();
    in_valid <= 1'b0;
    while (cmds_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input ls_pkg::cfg_idx_e idx,
                           input logic [ls_pkg::CfgDataW-1:0] val);
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic set_config(input ls_pkg::cfg_t c);
    drain_ticks();
    cfg_we <= 1'b1;
    write_reg(ls_pkg::CFG_WHEELED,         {15'd0, c.wheeled});
    write_reg(ls_pkg::CFG_THROTTLE_MIN,    {5'd0, c.throttle_min});
    write_reg(ls_pkg::CFG_THROTTLE_MAX,    {5'd0, c.throttle_max});
    write_reg(ls_pkg::CFG_RAMP_STEP,       {7'd0, c.ramp_step});
    write_reg(ls_pkg::CFG_RAMP_PERIOD_MS,  c.ramp_period_ms);
    write_reg(ls_pkg::CFG_IDLE_SPINUP_MS,  c.idle_spinup_ms);
    write_reg(ls_pkg::CFG_EXIT_TIMEOUT_MS, c.exit_timeout_ms);
    write_reg(ls_pkg::CFG_DETECT_MS,       c.detect_ms);
    cfg_we <= 1'b0;
    regs = c;
    phases++;
  endtask

  function automatic ls_pkg::cfg_t make_cfg(input bit wheels, input int unsigned tmin, tmax,
                                            step, period, spinup, tmo, det);
    ls_pkg::cfg_t c;
    c.wheeled         = wheels;
    c.throttle_min    = 11'(tmin);
    c.throttle_max    = 11'(tmax);
    c.ramp_step       = 9'(step);
    c.ramp_period_ms  = 16'(period);
    c.idle_spinup_ms  = 16'(spinup);
    c.exit_timeout_ms = 16'(tmo);
    c.detect_ms       = 16'(det);
    return c;
  endfunction

  function automatic ls_pkg::cfg_t rand_cfg(input bit wheels);
    return make_cfg(wheels, $urandom_range(1000, 2000), $urandom_range(1000, 2000),
                    $urandom_range(1, 500), $urandom_range(1, 400), $urandom_range(1, 600),
                    ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 3000),
                    $urandom_range(1, 120));
  endfunction

  function automatic ls_pkg::item_t base_tick(input logic [31:0] now);
    ls_pkg::item_t t;
    t                = '0;
    t.now_ms         = now;
    t.plane_enabled  = 1'b1;
    t.launch_mode_on = 1'b1;
    t.throttle_mid   = 1'b1;
    t.armed          = 1'b1;
    t.rx_throttle    = 12'd1500;
    return t;
  endfunction

  // Every field random (rx throttle kept within 800 to 2200), time sometimes jumps anywhere
  function automatic ls_pkg::item_t noise_tick();
    ls_pkg::item_t t;
    t.now_ms         = ($urandom_range(0, 3) == 0) ? $urandom : tick_ms + $urandom_range(0, 100);
    t.plane_enabled  = 1'($urandom);
    t.launch_mode_on = 1'($urandom);
    t.throttle_mid   = 1'($urandom);
    t.armed          = 1'($urandom);
    t.pitch_accel    = 16'($urandom);
    t.roll_accel     = 16'($urandom);
    t.yaw_rate_mrad  = 16'($urandom);
    t.tilt_ok        = 1'($urandom);
    t.ground_speed   = 16'($urandom);
    t.rx_throttle    = 12'($urandom_range(800, 2200));
    t.sticks_moved   = 1'($urandom);
    tick_ms = t.now_ms;
    return t;
  endfunction

  // One tick of a launch attempt; throwing biases toward a cue near its threshold
  function automatic ls_pkg::item_t flight_tick(input bit arm_now, input bit throwing);
    ls_pkg::item_t t;
    int            k, s, yaw;
    k = $urandom_range(0, 99);
    if (k < 85) tick_ms += $urandom_range(1, 40);
    else if (k < 97) tick_ms += $urandom_range(41, 3000);
    else tick_ms += $urandom;
    t       = base_tick(tick_ms);
    t.armed = arm_now;
    if ($urandom_range(0, 39) == 0) t.plane_enabled = 1'b0;
    if ($urandom_range(0, 24) == 0) t.launch_mode_on = 1'b0;
    if ($urandom_range(0, 24) == 0) t.throttle_mid = 1'b0;
    t.sticks_moved = ($urandom_range(0, 59) == 0);
    t.tilt_ok      = ($urandom_range(0, 3) != 0);
    t.rx_throttle  = ($urandom_range(0, 3) == 0) ? 12'(1399 + $urandom_range(0, 1))
                                                 : 12'($urandom_range(800, 2200));
    t.ground_speed = 16'($urandom_range(0, 320));
    case (throwing ? $urandom_range(0, 2) : $urandom_range(3, 6))
      0: begin
        t.pitch_accel = 16'(-450 - int'($urandom_range(0, 3000)));
      end
      1: begin
        s   = ($urandom_range(0, 7) == 0) ? 1745 : int'($urandom_range(1746, 6000));
        yaw = $urandom_range(0, 1) ? s : -s;
        t.yaw_rate_mrad = 16'(yaw);
        t.pitch_accel   = 16'($urandom_range(0, 2000));
        t.roll_accel    = 16'((yaw * 3) / 10 + int'($urandom_range(0, 100)) - 50);
      end
      2: begin
        t.roll_accel   = 16'($urandom_range(0, 3000));
        t.ground_speed = 16'($urandom_range(290, 5000));
      end
      default: begin
        t.pitch_accel   = 16'(int'($urandom_range(0, 1200)) - 600);
        t.roll_accel    = 16'(int'($urandom_range(0, 1200)) - 600);
        t.yaw_rate_mrad = 16'(int'($urandom_range(0, 4000)) - 2000);
      end
    endcase
    return t;
  endfunction

  task automatic run_flights(input int n);
    int            sent, len, throw_at;
    bit            arm_now;
    ls_pkg::item_t t;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 9) == 0) begin
        send_tick(noise_tick());
        sent++;
      end else begin
        len      = $urandom_range(5, 80);
        throw_at = $urandom_range(0, 10);
        arm_now  = 1'($urandom_range(0, 1));
        for (int i = 0; i < len && sent < n; i++) begin
          if ($urandom_range(0, 29) == 0) arm_now = !arm_now;
          send_tick(flight_tick(arm_now, i >= throw_at && $urandom_range(0, 9) != 0));
          sent++;
        end
        // disarmed with throttle off center: sequence restarts
        if (sent < n && $urandom_range(0, 3) != 0) begin
          t              = flight_tick(1'b0, 1'b0);
          t.armed        = 1'b0;
          t.throttle_mid = 1'b0;
          send_tick(t);
          sent++;
        end
      end
    end
  endtask

  task automatic test_directed();
    ls_pkg::item_t t;
    // plane off, every sensor at an extreme, time about to wrap
    t = base_tick(32'hFFFF_FFF0);
    t.plane_enabled = 1'b0;
    t.pitch_accel   = 16'sh8000;
    t.roll_accel    = 16'sh7FFF;
    t.yaw_rate_mrad = 16'sh8000;
    t.tilt_ok       = 1'b1;
    t.ground_speed  = 16'hFFFF;
    t.rx_throttle   = 12'd2200;
    t.sticks_moved  = 1'b1;
    send_tick(t);
    t = base_tick(32'd5);  t.armed = 1'b0; t.throttle_mid = 1'b0;         send_tick(t);
    t = base_tick(32'd10); t.armed = 1'b0;                                send_tick(t);
    t = base_tick(32'd20); t.pitch_accel = -16'sd451; t.tilt_ok = 1'b1;   send_tick(t);
    t = base_tick(32'd30); t.pitch_accel = -16'sd450; t.tilt_ok = 1'b1;   send_tick(t);
    t = base_tick(32'd40);
    t.yaw_rate_mrad = 16'sd1746; t.pitch_accel = 16'sd1; t.roll_accel = 16'sd524;
    send_tick(t);
    t = base_tick(32'd50);
    t.yaw_rate_mrad = -16'sd1746; t.pitch_accel = 16'sd1; t.roll_accel = -16'sd524;
    send_tick(t);
    t = base_tick(32'd60); t.roll_accel = 16'sd1; t.ground_speed = 16'd301; send_tick(t);
    t = base_tick(32'd75); t.roll_accel = 16'sd1; t.ground_speed = 16'd301; send_tick(t);
    // launched: idle throttle, stale spinup restart, full throttle, timeout twice
    t = base_tick(32'd80);    t.armed = 1'b0;                             send_tick(t);
    t = base_tick(32'd1600);                                              send_tick(t);
    t = base_tick(32'd2000);  t.rx_throttle = 12'd800;                    send_tick(t);
    t = base_tick(32'd3100);                                              send_tick(t);
    t = base_tick(32'd5100);                                              send_tick(t);
    t = base_tick(32'd10100); t.rx_throttle = 12'd1399;                   send_tick(t);
    t = base_tick(32'd10110);                                             send_tick(t);
    t = base_tick(32'd10120); t.armed = 1'b0; t.throttle_mid = 1'b0;      send_tick(t);
    // relaunch ended by the sticks
    t = base_tick(32'd10200); t.pitch_accel = -16'sd2000; t.tilt_ok = 1'b1; send_tick(t);
    t = base_tick(32'd10300); t.pitch_accel = -16'sd2000; t.tilt_ok = 1'b1; send_tick(t);
    t = base_tick(32'd10310); t.sticks_moved = 1'b1;                      send_tick(t);
    t = base_tick(32'd10320); t.launch_mode_on = 1'b0;                    send_tick(t);
    tick_ms = 32'd10320;
  endtask

  task automatic test_hand_launch();
    for (int p = 0; p < 3; p++) begin
      set_config(rand_cfg(1'b0));
      run_flights(200);
    end
  endtask

  task automatic test_wheeled();
    // ramp step that overshoots 2047 just below the ceiling
    set_config(make_cfg(1'b1, 1100, 2000, 499, 5, 100, 2000, 40));
    run_flights(200);
    for (int p = 0; p < 2; p++) begin
      set_config(rand_cfg(1'b1));
      run_flights(200);
    end
  endtask

  task automatic test_config_extremes();
    set_config(make_cfg(1'b0, 1000, 1000, 1, 1, 1, 0, 1));
    run_flights(100);
    set_config(make_cfg(1'b1, 2000, 2000, 500, 65535, 65535, 65535, 65535));
    run_flights(100);
    set_config(make_cfg(1'b0, 2000, 1000, 500, 65535, 65535, 65535, 65535));
    run_flights(100);
    set_config(make_cfg(1'b1, 1000, 2000, 1, 1, 1, 1, 1));
    run_flights(100);
  endtask

  task automatic test_backpressure();
    set_config(make_cfg(1'b0, 1100, 1700, 100, 300, 200, 600, 40));
    no_idle  = 1'b1;
    hold_req = 1'b1;
    repeat (40) send_tick(flight_tick(1'b1, 1'b1));
    no_idle = 1'b0;
    drain_ticks();
    repeat (20) send_tick(flight_tick(1'b0, 1'b1));
    drain_ticks();
  endtask

  task automatic test_mixed();
    set_config(rand_cfg(1'($urandom_range(0, 1))));
    no_idle = 1'b1;
    run_flights(120);
    no_idle = 1'b0;
    set_config(rand_cfg(1'($urandom_range(0, 1))));
    run_flights(120);
  endtask

  initial begin
    regs = make_cfg(ls_pkg::RstWheeled, ls_pkg::RstThrottleMin, ls_pkg::RstThrottleMax,
                    ls_pkg::RstRampStep, ls_pkg::RstRampPeriod, ls_pkg::RstIdleSpinup,
                    ls_pkg::RstExitTimeout, ls_pkg::RstDetect);
    cue_ms   = '0;
    cue_t    = '0;
    airborne = 1'b0;
    restart_sequence();
    repeat (12) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_directed();
    test_hand_launch();
    test_wheeled();
    test_config_extremes();
    test_backpressure();
    test_mixed();
    drain_ticks();

    $display("Ran %0d control ticks under %0d register settings: hand launch, wheeled ramp,",
             ticks_sent, phases);
    $display("register extremes and a long output hold; %0d result items checked.",
             results_seen);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/ls_pkg.sv
hdl/ls_cfg.sv
hdl/ls_cue.sv
hdl/ls_step.sv
hdl/launch_sequencer.sv
test/launch_sequencer_tb.sv
